/* rtl/vumb_pkg.sv */
// Package for the level meter with ballistics, peak hold and clip hold.
// Types, register indexes, item kinds and level constants; no dependencies.
`timescale 1ns / 1ps

package vumb_pkg;

  localparam int LEVEL_FRAC_BITS = 14;
  localparam int LVL_W           = 15;
  localparam int AGE_W           = 11;
  localparam int TICKS_W         = 10;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 15;

  localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1 << LEVEL_FRAC_BITS);
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'((1 << LEVEL_FRAC_BITS)
                                               + (1 << (LEVEL_FRAC_BITS - 1)));
  localparam logic [AGE_W-1:0] AGE_SAT = AGE_W'(1 << TICKS_W);

  typedef enum logic [2:0] {
    KIND_TICK      = 3'd0,
    KIND_LVL_AUTO  = 3'd1,
    KIND_LVL_FLAG  = 3'd2,
    KIND_RST_PEAK  = 3'd3,
    KIND_RST_CLIP  = 3'd4,
    KIND_RST_BOTH  = 3'd5
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RISE_RATE   = 3'd0,
    REG_FALL_RATE   = 3'd1,
    REG_PEAK_EN     = 3'd2,
    REG_PEAK_TICKS  = 3'd3,
    REG_CLIP_TICKS  = 3'd4,
    REG_DECAY_STEP  = 3'd5,
    REG_YELLOW_THR  = 3'd6,
    REG_RED_THR     = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    ZONE_GREEN  = 2'd0,
    ZONE_YELLOW = 2'd1,
    ZONE_RED    = 2'd2
  } zone_e;

  typedef struct packed {
    logic [LVL_W-1:0]   rise_rate;
    logic [LVL_W-1:0]   fall_rate;
    logic               peak_en;
    logic [TICKS_W-1:0] peak_ticks;
    logic [TICKS_W-1:0] clip_ticks;
    logic [LVL_W-1:0]   decay_step;
    logic [LVL_W-1:0]   yellow_thr;
    logic [LVL_W-1:0]   red_thr;
  } cfg_t;

  typedef struct packed {
    logic             changed;
    zone_e            peak_zone;
    zone_e            display_zone;
    logic             clip_lit;
    logic [LVL_W-1:0] peak_level;
    logic [LVL_W-1:0] display_level;
  } result_t;

  function automatic zone_e zone_of(logic [LVL_W-1:0] v, logic [LVL_W-1:0] yellow,
                                    logic [LVL_W-1:0] red);
    zone_e z;
    if (v >= red) begin
      z = ZONE_RED;
    end else if (v >= yellow) begin
      z = ZONE_YELLOW;
    end else begin
      z = ZONE_GREEN;
    end
    return z;
  endfunction

endpackage

/* rtl/vumb_cfg_regs.sv */
// Configuration register file of the level meter.
// Depends on vumb_pkg for the register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module vumb_cfg_regs import vumb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [CFG_DATA_W-1:0] wr_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (reg_idx_e'(wr_idx_i))
        REG_RISE_RATE:  cfg_d.rise_rate  = wr_data_i[LVL_W-1:0];
        REG_FALL_RATE:  cfg_d.fall_rate  = wr_data_i[LVL_W-1:0];
        REG_PEAK_EN:    cfg_d.peak_en    = wr_data_i[0];
        REG_PEAK_TICKS: cfg_d.peak_ticks = wr_data_i[TICKS_W-1:0];
        REG_CLIP_TICKS: cfg_d.clip_ticks = wr_data_i[TICKS_W-1:0];
        REG_DECAY_STEP: cfg_d.decay_step = wr_data_i[LVL_W-1:0];
        REG_YELLOW_THR: cfg_d.yellow_thr = wr_data_i[LVL_W-1:0];
        REG_RED_THR:    cfg_d.red_thr    = wr_data_i[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rise_rate  <= LVL_W'(4096);
      cfg_q.fall_rate  <= LVL_W'(819);
      cfg_q.peak_en    <= 1'b1;
      cfg_q.peak_ticks <= TICKS_W'(50);
      cfg_q.clip_ticks <= TICKS_W'(100);
      cfg_q.decay_step <= LVL_W'(328);
      cfg_q.yellow_thr <= LVL_W'(11469);
      cfg_q.red_thr    <= LVL_W'(14746);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/vumb_core.sv */
// Meter state and its one-word update: slew, peak hold, clip hold, resets.
// Depends on vumb_pkg; produces the result word for the updated state.
`timescale 1ns / 1ps

module vumb_core import vumb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [2:0]  kind_i,
  input  logic [15:0] level_i,
  input  logic        clip_in_i,
  input  cfg_t        cfg_i,
  output result_t     res_o
);

  logic [LVL_W-1:0] shown_q, shown_d, goal_q, goal_d, peak_q, peak_d;
  logic [AGE_W-1:0] peak_age_q, peak_age_d, clip_age_q, clip_age_d;
  logic             clip_q, clip_d;
  logic             chg;

  logic [AGE_W-1:0] peak_age_inc, clip_age_inc;
  logic [LVL_W:0]   rise_sum;
  logic [LVL_W-1:0] shown_gap, slew_lvl, clamp_lvl;
  logic             auto_clip;

  assign peak_age_inc = (peak_age_q < AGE_SAT) ? peak_age_q + AGE_W'(1) : peak_age_q;
  assign clip_age_inc = (clip_age_q < AGE_SAT) ? clip_age_q + AGE_W'(1) : clip_age_q;

  assign rise_sum  = {1'b0, shown_q} + {1'b0, cfg_i.rise_rate};
  assign shown_gap = shown_q - goal_q;

  always_comb begin
    slew_lvl = shown_q;
    if (shown_q < goal_q) begin
      slew_lvl = (rise_sum < {1'b0, goal_q}) ? rise_sum[LVL_W-1:0] : goal_q;
    end else if (shown_q > goal_q) begin
      slew_lvl = (shown_gap <= cfg_i.fall_rate) ? goal_q : shown_q - cfg_i.fall_rate;
    end
  end

  always_comb begin
    if (level_i[15]) begin
      clamp_lvl = '0;
    end else if (level_i[LVL_W-1:0] > LVL_MAX) begin
      clamp_lvl = LVL_MAX;
    end else begin
      clamp_lvl = level_i[LVL_W-1:0];
    end
  end

  assign auto_clip = !level_i[15] && (level_i[LVL_W-1:0] >= LVL_ONE);

  always_comb begin
    shown_d    = shown_q;
    goal_d     = goal_q;
    peak_d     = peak_q;
    peak_age_d = peak_age_q;
    clip_d     = clip_q;
    clip_age_d = clip_age_q;
    chg        = 1'b0;
    case (kind_e'(kind_i))
      KIND_TICK: begin
        peak_age_d = peak_age_inc;
        clip_age_d = clip_age_inc;
        shown_d    = slew_lvl;
        chg        = (shown_q != goal_q);
        if (cfg_i.peak_en) begin
          if (slew_lvl > peak_q) begin
            peak_d     = slew_lvl;
            peak_age_d = '0;
            chg        = 1'b1;
          end else if ((peak_q != '0) && (peak_age_inc > {1'b0, cfg_i.peak_ticks})) begin
            peak_d = (peak_q > cfg_i.decay_step) ? peak_q - cfg_i.decay_step : '0;
            chg    = 1'b1;
          end
        end
        if (clip_q && (clip_age_inc > {1'b0, cfg_i.clip_ticks})) begin
          clip_d = 1'b0;
          chg    = 1'b1;
        end
      end
      KIND_LVL_AUTO: begin
        goal_d = clamp_lvl;
        if (auto_clip) begin
          clip_d     = 1'b1;
          clip_age_d = '0;
        end
      end
      KIND_LVL_FLAG: begin
        goal_d = clamp_lvl;
        if (clip_in_i) begin
          clip_d     = 1'b1;
          clip_age_d = '0;
        end
      end
      KIND_RST_PEAK: begin
        peak_d     = '0;
        peak_age_d = AGE_SAT;
        chg        = 1'b1;
      end
      KIND_RST_CLIP: begin
        clip_d     = 1'b0;
        clip_age_d = AGE_SAT;
        chg        = 1'b1;
      end
      KIND_RST_BOTH: begin
        peak_d     = '0;
        peak_age_d = AGE_SAT;
        clip_d     = 1'b0;
        clip_age_d = AGE_SAT;
        chg        = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_q    <= '0;
      goal_q     <= '0;
      peak_q     <= '0;
      peak_age_q <= AGE_SAT;
      clip_q     <= 1'b0;
      clip_age_q <= AGE_SAT;
    end else if (step_i) begin
      shown_q    <= shown_d;
      goal_q     <= goal_d;
      peak_q     <= peak_d;
      peak_age_q <= peak_age_d;
      clip_q     <= clip_d;
      clip_age_q <= clip_age_d;
    end
  end

  always_comb begin
    res_o.display_level = shown_d;
    res_o.peak_level    = peak_d;
    res_o.clip_lit      = clip_d;
    res_o.display_zone  = zone_of(shown_d, cfg_i.yellow_thr, cfg_i.red_thr);
    res_o.peak_zone     = zone_of(peak_d, cfg_i.yellow_thr, cfg_i.red_thr);
    res_o.changed       = chg;
  end

endmodule

/* rtl/vu_meter_ballistics_peak_clip_hold.sv */
// Level meter with ballistics, peak hold and clip hold, unsigned Q1.14 levels.
// Depends on vumb_pkg, vumb_cfg_regs and vumb_core.
`timescale 1ns / 1ps

// One word in, one result word out. Each word passes an input register, the
// update logic that also writes the meter state, and an output register. A
// new word is taken every cycle while the output is not stalled; the state
// update of one word is the only dependency between words and it is written
// together with the output register. Word kinds on tuser: tick, level with
// automatic clip, level with explicit clip flag, reset peak, reset clip,
// reset both. Write configuration only while no word is in flight.
module vu_meter_ballistics_peak_clip_hold import vumb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,  // level[15:0], clip_in[16], zero pad
  input  logic [2:0]            s_axis_tuser,  // kind[2:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,  // display_level[14:0], peak_level[29:15],
                                               // clip_lit[30], display_zone[32:31],
                                               // peak_zone[34:33], changed[35], zero pad
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t    cfg;
  result_t res;

  logic        in_vld_q;
  logic [2:0]  kind_q;
  logic [15:0] level_q;
  logic        clip_in_q;
  logic        out_vld_q;
  result_t     out_q;
  logic        step;

  assign cfg_ready_o   = 1'b1;
  assign step          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || step;

  vumb_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  vumb_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .kind_i    (kind_q),
    .level_i   (level_q),
    .clip_in_i (clip_in_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      kind_q    <= s_axis_tuser;
      level_q   <= s_axis_tdata[15:0];
      clip_in_q <= s_axis_tdata[16];
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_q};

endmodule

/* tb/vu_meter_ballistics_peak_clip_hold_tb.sv */
// Testbench for the level meter: drives tick, level and reset words through several
// register settings and checks every result word against an in-bench meter prediction.
// Depends on vumb_pkg and vu_meter_ballistics_peak_clip_hold.
`timescale 1ns / 1ps

module vu_meter_ballistics_peak_clip_hold_tb import vumb_pkg::*; ();

  // kinds outside the defined set; the meter must leave its state alone
  localparam logic [2:0] KIND_RSVD6 = 3'd6;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;

  class meter_checker;
    cfg_t        cfg;
    int unsigned shown, goal, peak, peak_age, clip_age;
    bit          clip;
    result_t     pending_readings[$];
    int unsigned fails;

    function new();
      cfg.rise_rate  = 15'd4096;
      cfg.fall_rate  = 15'd819;
      cfg.peak_en    = 1'b1;
      cfg.peak_ticks = 10'd50;
      cfg.clip_ticks = 10'd100;
      cfg.decay_step = 15'd328;
      cfg.yellow_thr = 15'd11469;
      cfg.red_thr    = 15'd14746;
      shown    = 0;
      goal     = 0;
      peak     = 0;
      peak_age = AGE_SAT;
      clip     = 1'b0;
      clip_age = AGE_SAT;
      fails    = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_RISE_RATE:  cfg.rise_rate  = v;
        REG_FALL_RATE:  cfg.fall_rate  = v;
        REG_PEAK_EN:    cfg.peak_en    = v[0];
        REG_PEAK_TICKS: cfg.peak_ticks = v[TICKS_W-1:0];
        REG_CLIP_TICKS: cfg.clip_ticks = v[TICKS_W-1:0];
        REG_DECAY_STEP: cfg.decay_step = v;
        REG_YELLOW_THR: cfg.yellow_thr = v;
        REG_RED_THR:    cfg.red_thr    = v;
        default: ;
      endcase
    endfunction

    function zone_e level_zone(int unsigned v);
      if (v >= cfg.red_thr) begin
        return ZONE_RED;
      end else if (v >= cfg.yellow_thr) begin
        return ZONE_YELLOW;
      end
      return ZONE_GREEN;
    endfunction

    function bit advance_tick();
      bit chg;
      chg = 1'b0;
      if (peak_age < AGE_SAT) peak_age++;
      if (clip_age < AGE_SAT) clip_age++;
      if (shown < goal) begin
        shown = (shown + cfg.rise_rate < goal) ? shown + cfg.rise_rate : goal;
        chg = 1'b1;
      end else if (shown > goal) begin
        shown = (shown - goal <= cfg.fall_rate) ? goal : shown - cfg.fall_rate;
        chg = 1'b1;
      end
      if (cfg.peak_en) begin
        if (shown > peak) begin
          peak = shown;
          peak_age = 0;
          chg = 1'b1;
        end else if (peak > 0 && peak_age > cfg.peak_ticks) begin
          peak = (peak > cfg.decay_step) ? peak - cfg.decay_step : 0;
          chg = 1'b1;
        end
      end
      if (clip && clip_age > cfg.clip_ticks) begin
        clip = 1'b0;
        chg = 1'b1;
      end
      return chg;
    endfunction

    function void take_goal(int signed v);
      if (v < 0) begin
        goal = 0;
      end else if (v > int'(LVL_MAX)) begin
        goal = LVL_MAX;
      end else begin
        goal = v;
      end
    endfunction

    function void take_word(logic [2:0] kind, logic [15:0] level, logic clip_in);
      int signed sv;
      bit        chg;
      result_t   r;
      sv  = $signed(level);
      chg = 1'b0;
      case (kind)
        KIND_TICK: chg = advance_tick();
        KIND_LVL_AUTO: begin
          take_goal(sv);
          if (sv >= int'(LVL_ONE)) begin
            clip = 1'b1;
            clip_age = 0;
          end
        end
        KIND_LVL_FLAG: begin
          take_goal(sv);
          if (clip_in) begin
            clip = 1'b1;
            clip_age = 0;
          end
        end
        KIND_RST_PEAK: begin
          peak = 0;
          peak_age = AGE_SAT;
          chg = 1'b1;
        end
        KIND_RST_CLIP: begin
          clip = 1'b0;
          clip_age = AGE_SAT;
          chg = 1'b1;
        end
        KIND_RST_BOTH: begin
          peak = 0;
          peak_age = AGE_SAT;
          clip = 1'b0;
          clip_age = AGE_SAT;
          chg = 1'b1;
        end
        default: ;
      endcase
      r.display_level = shown[LVL_W-1:0];
      r.peak_level    = peak[LVL_W-1:0];
      r.clip_lit      = clip;
      r.display_zone  = level_zone(shown);
      r.peak_zone     = level_zone(peak);
      r.changed       = chg;
      pending_readings.push_back(r);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        fails++;
      end
    endfunction

    function void check_word(logic [39:0] data);
      result_t got, want;
      got = result_t'(data[35:0]);
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, data);
        fails++;
        return;
      end
      want = pending_readings.pop_front();
      compare("display_level", want.display_level, got.display_level);
      compare("peak_level", want.peak_level, got.peak_level);
      compare("clip_lit", want.clip_lit, got.clip_lit);
      compare("display_zone", want.display_zone, got.display_zone);
      compare("peak_zone", want.peak_zone, got.peak_zone);
      compare("changed", want.changed, got.changed);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata = '0;  // level[15:0], clip_in[16], zero pad
  logic [2:0]            s_axis_tuser = '0;  // kind[2:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [39:0]           m_axis_tdata;       // display_level, peak_level, clip_lit,
                                             // display_zone, peak_zone, changed
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic        calm = 1'b0;
  int unsigned stall_left = 0;

  meter_checker meter = new();

  vu_meter_ballistics_peak_clip_hold dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // input words are noted before results are checked in the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        meter.take_word(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[16]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        meter.check_word(m_axis_tdata);
      end
    end
  end

  // receiver stalls in bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(1, 16);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_word(input logic [2:0] kind, input logic [15:0] level,
                           input logic clip_in);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {7'b0, clip_in, level};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (meter.pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_meter(input int unsigned rise, input int unsigned fall,
                               input int unsigned en, input int unsigned pticks,
                               input int unsigned cticks, input int unsigned step,
                               input int unsigned yel, input int unsigned red);
    int unsigned vals[8];
    reg_idx_e    idx;
    vals = '{rise, fall, en, pticks, cticks, step, yel, red};
    drain();
    for (int i = 0; i < 8; i++) begin
      idx = reg_idx_e'(i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= CFG_DATA_W'(vals[i]);
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      meter.set_reg(idx, CFG_DATA_W'(vals[i]));
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'($urandom_range(0, int'(LVL_MAX)));
      2: return 16'(int'(LVL_ONE) - 2 + $urandom_range(0, 4));
      3: return 16'(int'(LVL_MAX) - 2 + $urandom_range(0, 4));
      default: return 16'($urandom_range(0, 2000));
    endcase
  endfunction

  task automatic run_random(input int n);
    int unsigned r;
    logic [2:0]  kind;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) kind = KIND_TICK;
      else if (r < 65) kind = KIND_LVL_AUTO;
      else if (r < 80) kind = KIND_LVL_FLAG;
      else if (r < 85) kind = KIND_RST_PEAK;
      else if (r < 90) kind = KIND_RST_CLIP;
      else if (r < 94) kind = KIND_RST_BOTH;
      else if (r < 97) kind = KIND_RSVD6;
      else kind = KIND_RSVD7;
      send_word(kind, pick_level(), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic program_random();
    program_meter($urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom_range(0, 24576),
                  $urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom_range(0, 24576),
                  $urandom_range(0, 1), $urandom_range(0, 12), $urandom_range(0, 12),
                  $urandom_range(0, 3000), $urandom_range(6000, 16000),
                  $urandom_range(12000, 24576));
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: clamps, clip boundary, every kind
    send_word(KIND_LVL_AUTO, 16'd16384, 1'b0);
    repeat (4) send_word(KIND_TICK, 16'hffff, 1'b1);
    send_word(KIND_LVL_AUTO, 16'h7fff, 1'b0);
    repeat (3) send_word(KIND_TICK, 16'h0000, 1'b0);
    send_word(KIND_LVL_FLAG, 16'h8000, 1'b1);
    send_word(KIND_LVL_FLAG, 16'd16383, 1'b0);
    repeat (2) send_word(KIND_TICK, 16'h5555, 1'b0);
    send_word(KIND_LVL_AUTO, 16'd16383, 1'b1);
    send_word(KIND_LVL_AUTO, 16'hffff, 1'b0);
    send_word(KIND_TICK, 16'h0000, 1'b0);
    send_word(KIND_RST_PEAK, 16'haaaa, 1'b1);
    send_word(KIND_RST_CLIP, 16'h0000, 1'b0);
    send_word(KIND_RST_BOTH, 16'h0000, 1'b0);
    send_word(KIND_RSVD6, 16'd20000, 1'b1);
    send_word(KIND_RSVD7, 16'd20000, 1'b1);
    send_word(KIND_TICK, 16'h0000, 1'b0);
    run_random(40);

    program_meter(24576, 24576, 1, 0, 0, 24576, 24576, 24576);
    run_random(50);
    program_meter(0, 0, 0, 0, 0, 0, 0, 0);
    run_random(40);
    // stalled slew and zero decay step
    program_meter(0, 0, 1, 0, 1, 0, 0, 0);
    run_random(40);
    // yellow above red
    program_meter(5000, 3000, 1, 3, 5, 2000, 20000, 8000);
    run_random(60);
    program_meter(1500, 700, 0, 2, 2, 500, 11469, 14746);
    run_random(60);
    program_meter(8192, 1024, 1, 1023, 1023, 16384, 1, 24575);
    run_random(60);
    repeat (2) begin
      program_random();
      run_random(60);
    end
    program_random();
    calm <= 1'b1;
    run_random(60);

    drain();
    repeat (8) @(posedge clk_i);
    if (meter.fails == 0 && meter.pending_readings.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

/* files.f */
rtl/vumb_pkg.sv
rtl/vumb_cfg_regs.sv
rtl/vumb_core.sv
rtl/vu_meter_ballistics_peak_clip_hold.sv
tb/vu_meter_ballistics_peak_clip_hold_tb.sv
